// ===== rtl/core/spherical_fold_transform_assert.svh =====
// Assertion macros for the spherical fold transform.
`ifndef SPHERICAL_FOLD_TRANSFORM_ASSERT_SVH
`define SPHERICAL_FOLD_TRANSFORM_ASSERT_SVH
`ifndef ASSERT_OFF
`define SFT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SFT_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SFT_ASSERT(label, clk, rst, prop, msg)
`define SFT_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== rtl/core/sft_pkg.sv =====
// Package of types and constants for the spherical fold transform.
package sft_pkg;
   localparam int COORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 24;
   localparam int DERIV_W         = 32;
   localparam int REG_COUNT       = 8;
   localparam int ADDR_W          = 5;

   localparam logic [2:0] REG_OFFSET_X = 3'd0;
   localparam logic [2:0] REG_OFFSET_Y = 3'd1;
   localparam logic [2:0] REG_OFFSET_Z = 3'd2;
   localparam logic [2:0] REG_SCALE    = 3'd3;
   localparam logic [2:0] REG_MIN_RSQ  = 3'd4;
   localparam logic [2:0] REG_FIX_RSQ  = 3'd5;
   localparam logic [2:0] REG_MIN_FAC  = 3'd6;
   localparam logic [2:0] REG_DE_GAIN  = 3'd7;

   localparam logic [1:0] ZONE_NONE  = 2'd0;
   localparam logic [1:0] ZONE_MIN   = 2'd1;
   localparam logic [1:0] ZONE_FIXED = 2'd2;

   typedef struct packed {
      logic signed [COORD_WIDTH_DEF-1:0] in_x;
      logic signed [COORD_WIDTH_DEF-1:0] in_y;
      logic signed [COORD_WIDTH_DEF-1:0] in_z;
      logic [DERIV_W-1:0]                in_dist_deriv;
   } req_type;

   typedef struct packed {
      logic signed [COORD_WIDTH_DEF-1:0] out_x;
      logic signed [COORD_WIDTH_DEF-1:0] out_y;
      logic signed [COORD_WIDTH_DEF-1:0] out_z;
      logic [DERIV_W-1:0]                out_dist_deriv;
      logic [1:0]                        fold_zone;
      logic                              saturated;
   } rsp_type;
endpackage

// ===== rtl/core/spherical_fold_transform.sv =====
// Spherical fold transform top level: fold pipeline with register file.
// Throughput: one item per cycle unless the result stalls; the divider is unrolled one quotient bit per stage.
// A stalled result freezes the whole pipeline, output register included, and stalls req_.
// Reset (synchronous, active high) clears valid bits and loads register defaults.
module spherical_fold_transform import sft_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
`include "spherical_fold_transform_assert.svh"
   localparam int CW    = COORD_WIDTH_DEF;
   localparam int QW    = 32 + FRAC_BITS + 1;   // quotient bits, enough to flag > 2^32-1
   localparam int DW    = 32 + FRAC_BITS;       // dividend width
   localparam int NST   = 8 + QW;               // stages incl. output
   localparam logic [63:0] MAG_LIMIT = 64'h4000_0000_0000_0000;

   // ---------------- register file
   logic [31:0] cfg_ff [REG_COUNT];
   logic        wr_en;
   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite;
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff[REG_OFFSET_X] <= 32'd0;
         cfg_ff[REG_OFFSET_Y] <= 32'd0;
         cfg_ff[REG_OFFSET_Z] <= 32'd0;
         cfg_ff[REG_SCALE]    <= 32'd16777216;
         cfg_ff[REG_MIN_RSQ]  <= 32'd4194304;
         cfg_ff[REG_FIX_RSQ]  <= 32'd16777216;
         cfg_ff[REG_MIN_FAC]  <= 32'd67108864;
         cfg_ff[REG_DE_GAIN]  <= 32'd16777216;
      end else if (wr_en && csr_paddr[1:0] == 2'b00) begin
         cfg_ff[csr_paddr[4:2]] <= csr_pwdata;
      end
   end
   assign csr_prdata = (csr_paddr[1:0] == 2'b00) ? cfg_ff[csr_paddr[4:2]] : 32'd0;

   // ---------------- pipeline control: one global advance
   logic adv;
   logic [NST-1:0] vld_ff;
   assign adv       = !(vld_ff[NST-1] && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = vld_ff[NST-1];
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= {vld_ff[NST-2:0], req_valid};
   end

   // saturating truncated fixed product: a * b >> FRAC_BITS, clamped to 2^62
   function automatic logic [63:0] mulq(input logic [63:0] a, input logic [32:0] b,
                                        output logic sat);
      logic [96:0] p;
      logic [96:0] s;
      begin
         p = a * b;
         s = p >> FRAC_BITS;
         sat = (s > {33'd0, MAG_LIMIT});
         mulq = sat ? MAG_LIMIT : s[63:0];
      end
   endfunction

   // same, from the products of the low and high 32-bit halves of a
   function automatic logic [63:0] mulq_join(input logic [64:0] lo, input logic [64:0] hi,
                                             output logic sat);
      logic [96:0] s;
      begin
         s = (({32'd0, hi} << 32) + {32'd0, lo}) >> FRAC_BITS;
         sat = (s > {33'd0, MAG_LIMIT});
         mulq_join = sat ? MAG_LIMIT : s[63:0];
      end
   endfunction

   function automatic logic [31:0] umag32(input logic signed [31:0] v);
      umag32 = v[31] ? 32'(-v) : v;
   endfunction

   // ---------------- stage 1: squares
   req_type     s1_req_ff;
   logic [63:0] s1_sq_ff [3];
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_req_ff   <= req_data;
         s1_sq_ff[0] <= umag32(req_data.in_x) * umag32(req_data.in_x);
         s1_sq_ff[1] <= umag32(req_data.in_y) * umag32(req_data.in_y);
         s1_sq_ff[2] <= umag32(req_data.in_z) * umag32(req_data.in_z);
      end
   end

   // ---------------- stage 2: r2 and zone
   req_type     s2_req_ff;
   logic [65:0] sum_c;
   logic [65:0] r2_c;
   logic [65:0] s2_r2_ff;
   logic [1:0]  s2_zone_ff;
   assign sum_c = 66'(s1_sq_ff[0]) + 66'(s1_sq_ff[1]) + 66'(s1_sq_ff[2]);
   assign r2_c  = sum_c >> FRAC_BITS;
   always_ff @(posedge clock) begin
      if (adv) begin
         s2_req_ff <= s1_req_ff;
         s2_r2_ff  <= r2_c;
         if (r2_c < 66'(cfg_ff[REG_MIN_RSQ]))      s2_zone_ff <= ZONE_MIN;
         else if (r2_c < 66'(cfg_ff[REG_FIX_RSQ])) s2_zone_ff <= ZONE_FIXED;
         else                                      s2_zone_ff <= ZONE_NONE;
      end
   end

   // ---------------- divider: restoring, one quotient bit per stage
   // r2 < fixed_radius_sq < 2^32 whenever the quotient is used.
   req_type     dv_req_ff  [QW+1];
   logic [1:0]  dv_zone_ff [QW+1];
   logic [31:0] dv_den_ff  [QW+1];
   logic [32:0] dv_rem_ff  [QW+1];
   logic [QW-1:0] dv_q_ff  [QW+1];
   logic [DW-1:0] dv_num   ;
   assign dv_num = {cfg_ff[REG_FIX_RSQ], FRAC_BITS'(0)};
   always_ff @(posedge clock) begin
      if (adv) begin
         dv_req_ff[0]  <= s2_req_ff;
         dv_zone_ff[0] <= s2_zone_ff;
         dv_den_ff[0]  <= s2_r2_ff[31:0];
         dv_rem_ff[0]  <= '0;
         dv_q_ff[0]    <= '0;
      end
   end
   for (genvar k = 0; k < QW; k++) begin : g_div
      logic [33:0] trial;
      logic        nb;
      // bit k of quotient from MSB; dividend bit index QW-1-k (leading 0 bit first)
      assign nb    = (k == 0) ? 1'b0 : dv_num[(k == 0) ? 0 : QW-1-k];
      assign trial = {dv_rem_ff[k], nb} - {2'b00, dv_den_ff[k]};
      always_ff @(posedge clock) begin
         if (adv) begin
            dv_req_ff[k+1]  <= dv_req_ff[k];
            dv_zone_ff[k+1] <= dv_zone_ff[k];
            dv_den_ff[k+1]  <= dv_den_ff[k];
            if (!trial[33]) begin
               dv_rem_ff[k+1] <= trial[32:0];
               dv_q_ff[k+1]   <= {dv_q_ff[k][QW-2:0], 1'b1};
            end else begin
               dv_rem_ff[k+1] <= {dv_rem_ff[k][31:0], nb};
               dv_q_ff[k+1]   <= {dv_q_ff[k][QW-2:0], 1'b0};
            end
         end
      end
   end

   // ---------------- stage F: factor select
   req_type     f_req_ff;
   logic [1:0]  f_zone_ff;
   logic [32:0] f_fac_ff;
   logic        f_sat_ff;
   logic [QW-1:0] qv;
   assign qv = dv_q_ff[QW];
   always_ff @(posedge clock) begin
      if (adv) begin
         f_req_ff  <= dv_req_ff[QW];
         f_zone_ff <= dv_zone_ff[QW];
         f_sat_ff  <= 1'b0;
         unique case (dv_zone_ff[QW])
            ZONE_MIN:   f_fac_ff <= {1'b0, cfg_ff[REG_MIN_FAC]};
            ZONE_FIXED: begin
               if (dv_den_ff[QW] == 32'd0 || qv > QW'(33'hFFFF_FFFF)) begin
                  f_fac_ff <= 33'hFFFF_FFFF;
                  f_sat_ff <= 1'b1;
               end else begin
                  f_fac_ff <= 33'(qv);
               end
            end
            default:    f_fac_ff <= 33'(1) << FRAC_BITS;
         endcase
      end
   end

   // ---------------- stage M1: offset add, times |scale|; deriv times factor
   logic signed [32:0] m1_t   [3];
   logic [63:0]        m1_mag_ff [3];
   logic [2:0]         m1_neg_ff;
   logic [2:0]         m1_s;
   logic [63:0]        m1_d_ff;
   logic               m1_ds;
   logic [32:0]        m1_fac_ff;
   logic [1:0]         m1_zone_ff;
   logic               m1_sat_ff;
   logic signed [31:0] m1_in [3];
   logic signed [31:0] scl;
   logic [31:0]        sclm;
   assign m1_in[0] = f_req_ff.in_x;
   assign m1_in[1] = f_req_ff.in_y;
   assign m1_in[2] = f_req_ff.in_z;
   assign scl  = cfg_ff[REG_SCALE];
   assign sclm = umag32(scl);
   for (genvar a = 0; a < 3; a++) begin : g_m1
      logic [32:0] tm;
      logic [63:0] pr;
      logic        ps;
      assign m1_t[a] = 33'(m1_in[a]) + 33'(signed'(cfg_ff[REG_OFFSET_X + a]));
      assign tm = m1_t[a][32] ? 33'(-m1_t[a]) : m1_t[a];
      always_comb pr = mulq({31'd0, tm}, {1'b0, sclm}, ps);
      assign m1_s[a] = ps;
      always_ff @(posedge clock) begin
         if (adv) begin
            m1_mag_ff[a] <= pr;
            m1_neg_ff[a] <= m1_t[a][32] != scl[31];
         end
      end
   end
   logic [63:0] m1_dp;
   always_comb m1_dp = mulq({32'd0, f_req_ff.in_dist_deriv}, f_fac_ff, m1_ds);
   always_ff @(posedge clock) begin
      if (adv) begin
         m1_d_ff    <= m1_dp;
         m1_fac_ff  <= f_fac_ff;
         m1_zone_ff <= f_zone_ff;
         m1_sat_ff  <= f_sat_ff | (|m1_s) | m1_ds;
      end
   end

   // ---------------- stage M2: partial products, 32-bit halves times 33 bits
   logic [64:0] m2_lo_ff [3];
   logic [64:0] m2_hi_ff [3];
   logic [2:0]  m2_neg_ff;
   logic [64:0] m2_dlo_ff;
   logic [64:0] m2_dhi_ff;
   logic [1:0]  m2_zone_ff;
   logic        m2_sat_ff;
   logic [32:0] m2_gain;
   assign m2_gain = {1'b0, cfg_ff[REG_DE_GAIN]};
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            m2_lo_ff[i] <= m1_mag_ff[i][31:0] * m1_fac_ff;
            m2_hi_ff[i] <= m1_mag_ff[i][63:32] * m1_fac_ff;
         end
         m2_neg_ff  <= m1_neg_ff;
         m2_dlo_ff  <= m1_d_ff[31:0] * m2_gain;
         m2_dhi_ff  <= m1_d_ff[63:32] * m2_gain;
         m2_zone_ff <= m1_zone_ff;
         m2_sat_ff  <= m1_sat_ff;
      end
   end

   // ---------------- stage M3: join halves, shift, clamp
   logic [63:0] m3_mag_ff [3];
   logic [2:0]  m3_neg_ff;
   logic [2:0]  m3_s;
   logic [63:0] m3_d_ff;
   logic        m3_ds;
   logic [1:0]  m3_zone_ff;
   logic        m3_sat_ff;
   for (genvar a = 0; a < 3; a++) begin : g_m3
      logic [63:0] pr;
      logic        ps;
      always_comb pr = mulq_join(m2_lo_ff[a], m2_hi_ff[a], ps);
      assign m3_s[a] = ps;
      always_ff @(posedge clock) begin
         if (adv) begin
            m3_mag_ff[a] <= pr;
            m3_neg_ff[a] <= m2_neg_ff[a];
         end
      end
   end
   logic [63:0] m3_dp;
   always_comb m3_dp = mulq_join(m2_dlo_ff, m2_dhi_ff, m3_ds);
   always_ff @(posedge clock) begin
      if (adv) begin
         m3_d_ff    <= m3_dp;
         m3_zone_ff <= m2_zone_ff;
         m3_sat_ff  <= m2_sat_ff | (|m3_s) | m3_ds;
      end
   end

   // ---------------- stage O: sign, minus offset, clamp; deriv plus one
   rsp_type rsp_ff;
   logic [2:0]         o_s;
   logic signed [CW-1:0] o_v [3];
   localparam logic signed [65:0] HI_V = 66'((64'd1 << (CW-1)) - 64'd1);
   localparam logic signed [65:0] LO_V = -HI_V - 66'sd1;
   for (genvar a = 0; a < 3; a++) begin : g_o
      logic signed [65:0] w;
      logic signed [65:0] r;
      assign w = m3_neg_ff[a] ? -66'(m3_mag_ff[a]) : 66'(m3_mag_ff[a]);
      assign r = w - 66'(signed'(cfg_ff[REG_OFFSET_X + a]));
      always_comb begin
         o_s[a] = 1'b0;
         if (r > HI_V) begin
            o_v[a] = HI_V[CW-1:0]; o_s[a] = 1'b1;
         end else if (r < LO_V) begin
            o_v[a] = LO_V[CW-1:0]; o_s[a] = 1'b1;
         end else begin
            o_v[a] = r[CW-1:0];
         end
      end
   end
   logic [64:0] o_d;
   logic        o_ds;
   assign o_d  = 65'(m3_d_ff) + 65'd65536;
   assign o_ds = o_d > 65'h0_FFFF_FFFF;
   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff.out_x          <= o_v[0];
         rsp_ff.out_y          <= o_v[1];
         rsp_ff.out_z          <= o_v[2];
         rsp_ff.out_dist_deriv <= o_ds ? 32'hFFFF_FFFF : o_d[31:0];
         rsp_ff.fold_zone      <= m3_zone_ff;
         rsp_ff.saturated      <= m3_sat_ff | (|o_s) | o_ds;
      end
   end
   assign rsp_data = rsp_ff;

   // ---------------- checks
   `SFT_ASSERT(a_stall_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "result changed while stalled")
   `SFT_ASSERT(a_zone_legal, clock, reset, rsp_valid |-> rsp_data.fold_zone != 2'd3, "illegal fold zone")
   `SFT_ASSERT(a_req_stall, clock, reset, req_stall |-> rsp_valid && rsp_stall, "input stalled without output stall")
endmodule

// ===== tb/tb_spherical_fold_transform.sv =====
// Testbench for the spherical fold transform: directed table plus random points.
`timescale 1ns / 100ps

module tb_spherical_fold_transform import sft_pkg::*; ();

   localparam int HALF_PERIOD = 10;
   localparam int LATENCY     = 9 + COORD_WIDTH_DEF + FRAC_BITS_DEF;
   localparam int CYCLE_LIMIT = 600000;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 150;
   localparam logic [63:0] MAG_CAP  = 64'h4000_0000_0000_0000;
   localparam logic [63:0] Q_ONE    = 64'd1 << FRAC_BITS_DEF;
   localparam logic [31:0] DER_ONE  = 32'h0001_0000;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_stall;
   req_type       req_data;
   logic          rsp_valid;
   logic          rsp_stall;
   rsp_type       rsp_data;
   logic          csr_psel;
   logic          csr_penable;
   logic          csr_pwrite;
   logic [ADDR_W-1:0] csr_paddr;
   logic [31:0]   csr_pwdata;
   logic [31:0]   csr_prdata;
   logic          csr_pready;

   spherical_fold_transform u_top (.*);

   // shadow copy of the register file, updated with every csr write
   logic [31:0] fold_regs [REG_COUNT];
   // folded points still on their way through the pipeline
   rsp_type     fold_pending [$];
   int          err_count;
   int          cycle_count;
   int          rsp_hold;     // stall cycles drawn for the next result
   bit          no_idle;      // stretches with no idling on either side

   // directed point table; typed rows carry a hand-computed result
   typedef struct {
      req_type pt;
      bit      typed;
      rsp_type res;
   } point_row_type;
   point_row_type point_table [$];

   always begin
      clock = 1'b1;
      #HALF_PERIOD;
      clock = 1'b0;
      #HALF_PERIOD;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t timeout with %0d results pending", $realtime, fold_pending.size());
         $display("tb_spherical_fold_transform NOT OK");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------

   // floor(a*b / 2^FRAC), magnitude capped at 2^62
   function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b,
                                       inout bit sat);
      logic [127:0] prod;
      prod = ({64'd0, a} * {64'd0, b}) >> FRAC_BITS_DEF;
      if (prod > {64'd0, MAG_CAP}) begin
         sat = 1'b1;
         return MAG_CAP;
      end
      return prod[63:0];
   endfunction

   function automatic logic [63:0] mag64(input logic signed [63:0] v);
      return (v < 0) ? 64'(-v) : 64'(v);
   endfunction

   // one axis: shift by offset, scale, apply the zone factor, shift back, clamp
   function automatic logic signed [31:0] fold_axis(input logic signed [31:0] c,
                                                    input logic signed [31:0] off,
                                                    input logic [63:0] f, inout bit sat);
      logic signed [63:0] v, o, s, t, w, r;
      logic [63:0] m;
      bit neg;
      v = c;
      o = off;
      s = $signed(fold_regs[REG_SCALE]);
      t = v + o;
      neg = (t < 0) != (s < 0);
      m = qmul(qmul(mag64(t), mag64(s), sat), f, sat);
      w = neg ? -$signed(m) : $signed(m);
      r = w - o;
      if (r > 64'sh7FFF_FFFF) begin
         r = 64'sh7FFF_FFFF;
         sat = 1'b1;
      end
      if (r < -64'sh8000_0000) begin
         r = -64'sh8000_0000;
         sat = 1'b1;
      end
      return r[31:0];
   endfunction

   function automatic rsp_type fold_point(input req_type p);
      rsp_type res;
      logic [63:0] sq_sum, rsq, f, d;
      bit sat;
      sat = 1'b0;
      sq_sum = mag64(p.in_x) * mag64(p.in_x) + mag64(p.in_y) * mag64(p.in_y)
             + mag64(p.in_z) * mag64(p.in_z);
      rsq = sq_sum >> FRAC_BITS_DEF;
      if (rsq < fold_regs[REG_MIN_RSQ]) begin
         res.fold_zone = ZONE_MIN;
         f = fold_regs[REG_MIN_FAC];
      end else if (rsq < fold_regs[REG_FIX_RSQ]) begin
         res.fold_zone = ZONE_FIXED;
         if (rsq == 0) begin
            // inversion at the origin pins the factor
            f = 64'hFFFF_FFFF;
            sat = 1'b1;
         end else begin
            f = ({32'd0, fold_regs[REG_FIX_RSQ]} << FRAC_BITS_DEF) / rsq;
            if (f > 64'hFFFF_FFFF) begin
               f = 64'hFFFF_FFFF;
               sat = 1'b1;
            end
         end
      end else begin
         res.fold_zone = ZONE_NONE;
         f = Q_ONE;
      end
      res.out_x = fold_axis(p.in_x, fold_regs[REG_OFFSET_X], f, sat);
      res.out_y = fold_axis(p.in_y, fold_regs[REG_OFFSET_Y], f, sat);
      res.out_z = fold_axis(p.in_z, fold_regs[REG_OFFSET_Z], f, sat);
      d = qmul({32'd0, p.in_dist_deriv}, f, sat);
      d = qmul(d, {32'd0, fold_regs[REG_DE_GAIN]}, sat) + DER_ONE;
      if (d > 64'hFFFF_FFFF) begin
         d = 64'hFFFF_FFFF;
         sat = 1'b1;
      end
      res.out_dist_deriv = d[31:0];
      res.saturated = sat;
      return res;
   endfunction

   // ---------------------------------------------------------------
   // Result side: random stall, compare against the oldest expectation
   // ---------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (rsp_hold > 0 && !no_idle) begin
         rsp_stall <= 1'b1;
         rsp_hold  <= rsp_hold - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_hold <= $urandom_range(0, 16);
         if (fold_pending.size() == 0) begin
            $display("%0t unexpected result %h", $realtime, rsp_data);
            err_count++;
         end else begin
            want = fold_pending.pop_front();
            if (rsp_data.out_x !== want.out_x) begin
               $display("%0t out_x exp %h got %h", $realtime, want.out_x, rsp_data.out_x);
               err_count++;
            end
            if (rsp_data.out_y !== want.out_y) begin
               $display("%0t out_y exp %h got %h", $realtime, want.out_y, rsp_data.out_y);
               err_count++;
            end
            if (rsp_data.out_z !== want.out_z) begin
               $display("%0t out_z exp %h got %h", $realtime, want.out_z, rsp_data.out_z);
               err_count++;
            end
            if (rsp_data.out_dist_deriv !== want.out_dist_deriv) begin
               $display("%0t out_dist_deriv exp %h got %h", $realtime,
                        want.out_dist_deriv, rsp_data.out_dist_deriv);
               err_count++;
            end
            if (rsp_data.fold_zone !== want.fold_zone) begin
               $display("%0t fold_zone exp %0d got %0d", $realtime,
                        want.fold_zone, rsp_data.fold_zone);
               err_count++;
            end
            if (rsp_data.saturated !== want.saturated) begin
               $display("%0t saturated exp %0d got %0d", $realtime,
                        want.saturated, rsp_data.saturated);
               err_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------

   // APB write, setup phase then access phase, followed by an idle phase; called at a falling edge, returns at one
   task automatic csr_write(input logic [2:0] idx, input logic [31:0] val);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= ADDR_W'({idx, 2'b00});
      csr_pwdata  <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      fold_regs[idx] = val;
      @(negedge clock);
   endtask

   // present one point, wait for the handshake, queue its expected fold
   task automatic send_point(input req_type p, input bit typed, input rsp_type res);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= p;
      do @(posedge clock); while (req_stall);
      fold_pending.push_back(typed ? res : fold_point(p));
      @(negedge clock);
   endtask

   // coordinate spread over all magnitudes so every zone gets hit
   function automatic logic [31:0] rand_coord();
      logic [31:0] v;
      case ($urandom_range(0, 5))
         0: v = $urandom;
         1: v = 32'h0000_0000;
         2: v = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: begin
            v = $urandom >> $urandom_range(4, 31);
            if ($urandom_range(0, 1)) v = -v;
         end
      endcase
      return v;
   endfunction

   function automatic logic [31:0] rand_reg();
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
         default: return $urandom >> $urandom_range(4, 12);
      endcase
   endfunction

   function automatic req_type rand_point();
      req_type p;
      p.in_x = rand_coord();
      p.in_y = rand_coord();
      p.in_z = rand_coord();
      p.in_dist_deriv = $urandom_range(0, 3) == 0 ? $urandom : ($urandom >> $urandom_range(0, 24));
      return p;
   endfunction

   function automatic void add_row(input logic [31:0] x, input logic [31:0] y,
                                   input logic [31:0] z, input logic [31:0] d);
      point_row_type row;
      row.pt = '{x, y, z, d};
      row.typed = 1'b0;
      row.res = '0;
      point_table.push_back(row);
   endfunction

   function automatic void add_typed(input logic [31:0] x, input logic [31:0] d,
                                     input logic [31:0] ox, input logic [31:0] od,
                                     input logic [1:0] zone, input logic sat);
      point_row_type row;
      row.pt = '{x, 32'd0, 32'd0, d};
      row.typed = 1'b1;
      row.res = '{ox, 32'd0, 32'd0, od, zone, sat};
      point_table.push_back(row);
   endfunction

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin
      rsp_type dummy;
      logic [31:0] v;
      dummy = '0;
      err_count = 0;
      cycle_count = 0;
      rsp_hold = 0;
      no_idle = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      fold_regs[REG_OFFSET_X] = 32'd0;
      fold_regs[REG_OFFSET_Y] = 32'd0;
      fold_regs[REG_OFFSET_Z] = 32'd0;
      fold_regs[REG_SCALE]    = 32'd16777216;
      fold_regs[REG_MIN_RSQ]  = 32'd4194304;
      fold_regs[REG_FIX_RSQ]  = 32'd16777216;
      fold_regs[REG_MIN_FAC]  = 32'd67108864;
      fold_regs[REG_DE_GAIN]  = 32'd16777216;

      // reset-default results: origin folds to origin, extremes pass untouched
      add_typed(32'h0000_0000, 32'h0, 32'h0000_0000, DER_ONE, ZONE_MIN, 1'b0);
      add_typed(32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, DER_ONE, ZONE_NONE, 1'b0);
      add_typed(32'h8000_0000, 32'h0, 32'h8000_0000, DER_ONE, ZONE_NONE, 1'b0);
      add_typed(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, ZONE_NONE, 1'b1);
      // inside minimum radius, in the inversion shell, at the boundaries
      add_row(32'h0040_0000, 32'hFFC0_0000, 32'h0010_0000, 32'h0001_0000);
      add_row(32'h0080_0000, 32'h0000_0000, 32'h0000_0000, 32'h0002_0000);
      add_row(32'h007F_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0001_8000);
      add_row(32'h00B5_04F3, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
      add_row(32'hFF4A_FB0D, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000);
      add_row(32'h00FF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001);
      add_row(32'h0100_0000, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000);
      add_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
      add_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000);
      add_row(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001, 32'h1234_5678);
      add_row(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 32'hF0F0_F0F0);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int ph = 0; ph < PHASES; ph++) begin
         // reprogram only once the pipeline has drained
         if (ph > 0) begin
            wait (fold_pending.size() == 0);
            repeat (LATENCY + 4) @(negedge clock);
            for (int r = 0; r < REG_COUNT; r++) begin
               case (ph)
                  1: begin
                     // minimum radius of zero lets the origin reach the inversion
                     v = (r == REG_MIN_RSQ) ? 32'd0 : fold_regs[r];
                  end
                  2: v = (r == REG_SCALE) ? 32'h7FFF_FFFF :
                         (r <= REG_OFFSET_Z) ? 32'h7FFF_FFFF : 32'hFFFF_FFFF;
                  3: v = (r == REG_SCALE || r <= REG_OFFSET_Z) ? 32'h8000_0000 : 32'd0;
                  4: v = (r == REG_SCALE) ? 32'hFF00_0000 : rand_reg();
                  default: v = rand_reg();
               endcase
               csr_write(3'(r), v);
            end
         end
         no_idle = (ph == 5);
         if (ph == 0) begin
            foreach (point_table[i])
               send_point(point_table[i].pt, point_table[i].typed, point_table[i].res);
         end
         if (ph == 1)
            send_point('0, 1'b0, dummy);
         for (int n = 0; n < PHASE_ITEMS; n++)
            send_point(rand_point(), 1'b0, dummy);
         req_valid <= 1'b0;
         no_idle = 1'b0;
      end

      wait (fold_pending.size() == 0);
      repeat (LATENCY + 20) @(posedge clock);
      if (err_count == 0) begin
         $display("tb_spherical_fold_transform OK");
      end else begin
         $display("tb_spherical_fold_transform NOT OK");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/sft_pkg.sv
rtl/core/spherical_fold_transform.sv
tb/tb_spherical_fold_transform.sv
